>>> sv/hbem_pkg.sv
// hbem_pkg: shared types, register codes and address constants for the
// hashed block extent mapper. No dependencies.
`default_nettype none

package hbem_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_LAYOUT_MODE   = 2'd0;
	localparam logic [1:0] CFG_DATA_START    = 2'd1;
	localparam logic [1:0] CFG_HEADER_OFFSET = 2'd2;

	// layout codes; the unused code behaves as multi-file
	localparam logic [1:0] LAYOUT_MULTI    = 2'd0;
	localparam logic [1:0] LAYOUT_SINGLE   = 2'd1;
	localparam logic [1:0] LAYOUT_ENHANCED = 2'd2;
	localparam logic [1:0] LAYOUT_SPARE    = 2'd3;

	localparam logic [15:0] HEADER_OFFSET_RST = 16'hB000;
	localparam int unsigned HBEM_QUEUE_DEPTH  = 4;

	localparam logic [31:0] SHIFT_BLKS    = 32'd2;
	localparam logic [16:0] BLKS_PER_FILE = 17'd82824;
	localparam logic [13:0] BLKS_PER_FILE_OCT = 14'(BLKS_PER_FILE / 8);
	// under-estimating reciprocal: quotient is exact or one short
	localparam int unsigned RECIP_FILE_SHIFT = 40;
	localparam logic [26:0] RECIP_FILE =
		27'((64'd1 << RECIP_FILE_SHIFT) / 64'(BLKS_PER_FILE_OCT));
	// level-0 group of 408 blocks, 408 = 8 * 51; exact for 14-bit operands
	localparam logic [5:0]  BLKS_PER_L0_OCT = 6'd51;
	localparam int unsigned RECIP_L0_SHIFT  = 20;
	localparam logic [14:0] RECIP_L0 =
		15'(((64'd1 << RECIP_L0_SHIFT) + 64'(BLKS_PER_L0_OCT) - 64'd1) / 64'(BLKS_PER_L0_OCT));

	localparam logic [27:0] FRAG_BYTES = 28'hA290000;
	localparam logic [27:0] WRAP_SKIP  = 28'h0002000;
	localparam logic [27:0] OFF_STEP   = 28'h0000800;
	localparam logic [31:0] LEN_STEP   = 32'h00000800;
	localparam logic [31:0] LEN_SAT    = 32'hFFFFF800;

	typedef struct packed {
		logic [15:0] frag_file;
		logic [27:0] byte_offset;
		logic        run_start;
		logic        run_end;
	} hbem_item_t;

	typedef struct packed {
		logic full;
		logic valid;
	} hbem_qstat_t;

	typedef struct packed {
		logic [31:0] extent_bytes;
		logic [27:0] byte_offset;
		logic [15:0] frag_file;
		logic        last_extent;
	} hbem_result_t;

endpackage

`default_nettype wire

>>> sv/hashed_block_extent_mapper.sv
// Top level of the hashed block extent mapper: configuration registers,
// translation front, queue and merging back. Depends on hbem_pkg and submodules.
//
// One block number is taken per clock while the queue has room; it reaches the
// merger after six translation stages and the queue. The output buffer
// holds two results and sends one per clock while m_tready is high, so a block
// that closes two extents fills both slots and the queue absorbs the slip.
// Configuration must be written only when the block is idle.
`default_nettype none

module hashed_block_extent_mapper #(
	parameter int unsigned QUEUE_DEPTH = hbem_pkg::HBEM_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] block number
	input  wire logic        s_tuser,  // [0] run_start
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,  // [15:0] fragment file, [43:16] byte_offset,
	                                   // [75:44] extent_bytes, [79:76] zero
	output logic             m_tlast
);
	import hbem_pkg::*;

	logic [1:0]  layout_mode_q;
	logic [30:0] data_start_q;
	logic [15:0] header_offset_q;

	hbem_item_t  f_item, q_item;
	hbem_qstat_t qstat;
	logic        q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_mode_q   <= LAYOUT_MULTI;
			data_start_q    <= '0;
			header_offset_q <= HEADER_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LAYOUT_MODE:   layout_mode_q   <= cfg_wdata[1:0];
				CFG_DATA_START:    data_start_q    <= cfg_wdata;
				CFG_HEADER_OFFSET: header_offset_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	hbem_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.layout_mode   (layout_mode_q),
		.data_start    (data_start_q),
		.header_offset (header_offset_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.blk_num       (s_tdata),
		.run_start     (s_tuser),
		.run_end       (s_tlast),
		.qstat         (qstat),
		.push          (q_push),
		.item          (f_item)
	);

	hbem_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (f_item),
		.pop     (q_pop),
		.rd_item (q_item),
		.qstat   (qstat)
	);

	hbem_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (q_item),
		.qstat    (qstat),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> qstat.valid)
		else $error("merger took an item from an empty queue");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full)
		else $error("translation pushed into a full queue");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> qstat.full)
		else $error("input stalled while the queue had room");

	a_full_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.full && !q_pop) |=> qstat.full)
		else $error("queue lost an entry without a pop");

endmodule

`default_nettype wire

>>> sv/hbem_front.sv
// hbem_front: six-stage translation of a block number to fragment file and
// byte offset (constant-divisor arithmetic). Depends on hbem_pkg.
`default_nettype none

module hbem_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [1:0]           layout_mode,
	input  wire logic [30:0]          data_start,
	input  wire logic [15:0]          header_offset,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [31:0]          blk_num,
	input  wire logic                 run_start,
	input  wire logic                 run_end,
	input  wire hbem_pkg::hbem_qstat_t qstat,
	output logic                      push,
	output hbem_pkg::hbem_item_t      item
);
	import hbem_pkg::*;

	logic        en;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [1:0]  flg_s1, flg_s2, flg_s3, flg_s4, flg_s5, flg_s6;
	logic [31:0] t_s1, t_s2;
	logic [15:0] q0_s2, q0_s3;
	logic [17:0] r0_s3;
	logic [16:0] fblk_s4, fblk_s5;
	logic [15:0] fidx_s4, fidx_s5, fidx_s6;
	logic [7:0]  q2_s5;
	logic [27:0] a_s6;

	logic [31:0] t_in;
	logic [55:0] prod1;
	logic [31:0] r0_full;
	logic        r0_ge;
	logic [28:0] prod2;
	logic [7:0]  l0p1;
	logic [27:0] a_sum;
	logic        wrap;

	assign en       = !vld_s6 || !qstat.full;
	assign in_ready = en;
	assign push     = vld_s6 && !qstat.full;

	always_comb begin
		t_in = blk_num - {data_start, 1'b0};
		if (layout_mode == LAYOUT_ENHANCED) begin
			t_in = t_in + SHIFT_BLKS;
		end
		prod1   = 56'(t_s1[31:3]) * 56'(RECIP_FILE);
		r0_full = t_s2 - (32'(q0_s2) * 32'(BLKS_PER_FILE));
		r0_ge   = r0_s3 >= 18'(BLKS_PER_FILE);
		prod2   = 29'(fblk_s4[16:3]) * 29'(RECIP_L0);
		l0p1    = q2_s5 + 8'd2;
		a_sum   = {fblk_s5, 11'b0} + 28'({l0p1, 12'b0});
		if (layout_mode == LAYOUT_SINGLE) begin
			a_sum = a_sum + 28'(header_offset);
		end
		wrap = a_s6 >= FRAG_BYTES;
		item.frag_file   = fidx_s6 + 16'(wrap);
		item.byte_offset = wrap ? a_s6 - (FRAG_BYTES - WRAP_SKIP) : a_s6;
		item.run_start   = flg_s6[1];
		item.run_end     = flg_s6[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s1  <= {run_start, run_end};
			t_s1    <= t_in;
			flg_s2  <= flg_s1;
			t_s2    <= t_s1;
			q0_s2   <= prod1[RECIP_FILE_SHIFT +: 16];
			flg_s3  <= flg_s2;
			q0_s3   <= q0_s2;
			r0_s3   <= r0_full[17:0];
			flg_s4  <= flg_s3;
			fblk_s4 <= r0_ge ? 17'(r0_s3 - 18'(BLKS_PER_FILE)) : r0_s3[16:0];
			fidx_s4 <= q0_s3 + 16'(r0_ge);
			flg_s5  <= flg_s4;
			fblk_s5 <= fblk_s4;
			fidx_s5 <= fidx_s4;
			q2_s5   <= prod2[RECIP_L0_SHIFT +: 8];
			flg_s6  <= flg_s5;
			fidx_s6 <= fidx_s5;
			a_s6    <= a_sum;
		end
	end

endmodule

`default_nettype wire

>>> sv/hbem_queue.sv
// hbem_queue: short register queue between translation and extent merging.
// Depends on hbem_pkg.
`default_nettype none

module hbem_queue #(
	parameter int unsigned DEPTH = hbem_pkg::HBEM_QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire hbem_pkg::hbem_item_t  wr_item,
	input  wire logic                  pop,
	output hbem_pkg::hbem_item_t       rd_item,
	output hbem_pkg::hbem_qstat_t      qstat
);
	import hbem_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	hbem_item_t      mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign qstat.full  = count_q == CW'(DEPTH);
	assign qstat.valid = count_q != '0;
	assign rd_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/hbem_back.sv
// hbem_back: merges consecutive offsets into extents and buffers up to two
// results for the output stream. Depends on hbem_pkg.
`default_nettype none

module hbem_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hbem_pkg::hbem_item_t  item,
	input  wire hbem_pkg::hbem_qstat_t qstat,
	output logic                       pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [79:0]                m_tdata,
	output logic                       m_tlast
);
	import hbem_pkg::*;

	logic         open_valid_q;
	logic [15:0]  open_file_q;
	logic [27:0]  open_offset_q;
	logic [31:0]  open_length_q;
	logic [27:0]  prev_offset_q;
	hbem_result_t slot_q [2];
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	logic         consec, emit_a, taken;
	logic [1:0]   need, free_slots, n_wr;
	logic [27:0]  step;
	logic [31:0]  len_inc;
	logic [15:0]  nx_file;
	logic [27:0]  nx_offset;
	logic [31:0]  nx_length;
	hbem_result_t res_a, res_b, first;
	logic         wp;
	hbem_result_t head;

	always_comb begin
		step    = item.byte_offset - prev_offset_q;
		consec  = open_valid_q && !item.run_start && (step == OFF_STEP);
		emit_a  = open_valid_q && !consec;
		need    = {1'b0, emit_a} + {1'b0, item.run_end};
		taken   = m_tvalid && m_tready;
		free_slots = 2'd2 - cnt_q + {1'b0, taken};
		pop     = qstat.valid && (need <= free_slots);
		n_wr    = pop ? need : 2'd0;

		len_inc   = (open_length_q > LEN_SAT - LEN_STEP) ? LEN_SAT : open_length_q + LEN_STEP;
		nx_file   = consec ? open_file_q   : item.frag_file;
		nx_offset = consec ? open_offset_q : item.byte_offset;
		nx_length = consec ? len_inc       : LEN_STEP;

		res_a = '{extent_bytes: open_length_q, byte_offset: open_offset_q,
			frag_file: open_file_q, last_extent: item.run_start};
		res_b = '{extent_bytes: nx_length, byte_offset: nx_offset,
			frag_file: nx_file, last_extent: 1'b1};
		first = emit_a ? res_a : res_b;
		wp    = rd_ptr_q ^ cnt_q[0];

		head     = slot_q[rd_ptr_q];
		m_tvalid = cnt_q != 2'd0;
		m_tdata  = {4'b0, head.extent_bytes, head.byte_offset, head.frag_file};
		m_tlast  = head.last_extent;
	end

	always_ff @(posedge clk) begin
		if (n_wr != 2'd0) begin
			slot_q[wp] <= first;
		end
		if (n_wr == 2'd2) begin
			slot_q[!wp] <= res_b;
		end
		if (pop) begin
			open_file_q   <= nx_file;
			open_offset_q <= nx_offset;
			open_length_q <= nx_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_valid_q  <= 1'b0;
			prev_offset_q <= '1;
			rd_ptr_q      <= 1'b0;
			cnt_q         <= 2'd0;
		end else begin
			if (pop) begin
				open_valid_q  <= !item.run_end;
				prev_offset_q <= item.byte_offset;
			end
			rd_ptr_q <= rd_ptr_q ^ taken;
			cnt_q    <= cnt_q - {1'b0, taken} + n_wr;
		end
	end

endmodule

`default_nettype wire
